/* hw/rtl/audio_ramp_pattern_checker_top_macros.svh */
// Assertion helpers shared by the ramp checker RTL.
`ifndef AUDIO_RAMP_PATTERN_CHECKER_TOP_MACROS_SVH
`define AUDIO_RAMP_PATTERN_CHECKER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge.
`define ARPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge.
`define ARPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/arpc_pkg.sv */
package arpc_pkg;

   // Request kind codes.
   typedef enum logic {
      KIND_GEN = 1'b0,
      KIND_CAP = 1'b1
   } kind_type;

   // Configuration register indexes.
   localparam logic CSR_CHECK_CHANNELS  = 1'b0;
   localparam logic CSR_START_THRESHOLD = 1'b1;

   // Reset values and limits.
   localparam logic        CHECK_CHANNELS_RESET = 1'b1;
   localparam logic [15:0] THRESHOLD_RESET      = 16'd10;
   localparam logic [15:0] RAMP_MASK_TAGGED     = 16'h0FFF;
   localparam logic [15:0] RAMP_MASK_FULL       = 16'hFFFF;
   localparam logic [15:0] TALLY_MAX            = 16'hFFFF;
   localparam logic [31:0] CHAN_ERR_MAX         = 32'hFFFF_FFFF;
   localparam logic [31:0] SYNC_ERR_MAX         = 32'h7FFF_FFFF;
   localparam logic [31:0] SYNC_ERR_RESET       = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        check_channels;
      logic [15:0] start_threshold;
   } cfg_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  channel;
      logic        block_start;
      logic        frame_end;
      logic        block_end;
      logic [15:0] captured;
   } item_type;

   typedef struct packed {
      logic [15:0]        sample_out;
      logic [31:0]        channel_error_count;
      logic signed [31:0] sync_error_count;
      logic [11:0]        measured_latency;
      logic               is_started;
   } result_type;

endpackage

/* hw/rtl/audio_ramp_pattern_checker_top.sv */
// Audio loopback ramp tester: pattern generator and checker in one block.
// Request channel (req_*): kind 0 asks for one playback sample, kind 1 hands
// in one captured sample. Markers block_start, frame_end and block_end act on
// the request that carries them. Response channel (rsp_*): one response per
// request, in order, with the generated sample (0 for captures) and the
// error counters, latency and started flag after that request.
// Configuration (csr_*): index 0 is check_channels, index 1 is
// start_threshold; writes are taken in any cycle and should only be issued
// while no request is in flight.
// A request is held in the input register while the update logic
// computes its response, which is registered in the response register
// when the request advances. Throughput is one request per cycle while
// responses are taken, as the state update between those two registers
// is combinational.
// Reset clears the pipeline, the ramp and the counters (sync count to -1)
// and restores the register defaults. When the receiver stalls, the
// response register holds and the input register takes one more request,
// after which req_ready drops until the response is taken.
`include "audio_ramp_pattern_checker_top_macros.svh"

module audio_ramp_pattern_checker_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_kind,
   input  logic [3:0]  req_channel,
   input  logic        req_block_start,
   input  logic        req_frame_end,
   input  logic        req_block_end,
   input  logic [15:0] req_captured,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_sample_out,
   output logic [31:0] rsp_channel_error_count,
   output logic signed [31:0] rsp_sync_error_count,
   output logic [11:0] rsp_measured_latency,
   output logic        rsp_is_started,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_data
);

   arpc_pkg::cfg_type    cfg;
   arpc_pkg::item_type   req_item;
   arpc_pkg::item_type   item_ff;
   arpc_pkg::result_type result;
   arpc_pkg::result_type rsp_ff;
   logic                 in_valid_ff;
   logic                 rsp_valid_ff;
   logic                 advance;

   assign csr_ready = 1'b1;

   arpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Request payload bundled for the input register.
   always_comb begin
      req_item.kind        = arpc_pkg::kind_type'(req_kind);
      req_item.channel     = req_channel;
      req_item.block_start = req_block_start;
      req_item.frame_end   = req_frame_end;
      req_item.block_end   = req_block_end;
      req_item.captured    = req_captured;
   end

   // The held request moves on whenever the response register is free.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   arpc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_sample_out          = rsp_ff.sample_out;
   assign rsp_channel_error_count = rsp_ff.channel_error_count;
   assign rsp_sync_error_count    = rsp_ff.sync_error_count;
   assign rsp_measured_latency    = rsp_ff.measured_latency;
   assign rsp_is_started          = rsp_ff.is_started;

   // Checks on the pipeline and the checker state.
   `ARPC_ASSERT_SAME(a_ready_when_empty, clock, reset, !in_valid_ff, req_ready, "input register empty but request not ready")
   `ARPC_ASSERT_NEXT(a_item_held, clock, reset, in_valid_ff && !advance, in_valid_ff && $stable(item_ff), "stalled request lost")
   `ARPC_ASSERT_NEXT(a_started_sticky, clock, reset, rsp_valid_ff && rsp_ff.is_started && advance, rsp_ff.is_started, "checker left the started state")
   `ARPC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !in_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")

endmodule

/* hw/rtl/arpc_csr.sv */
module arpc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   input  logic              csr_index,
   input  logic [15:0]       csr_data,
   output arpc_pkg::cfg_type cfg
);

   logic        check_channels_ff;
   logic        check_channels_in;
   logic [15:0] start_threshold_ff;
   logic [15:0] start_threshold_in;

   // Register write decode.
   always_comb begin
      check_channels_in  = check_channels_ff;
      start_threshold_in = start_threshold_ff;
      if (csr_valid) begin
         unique case (csr_index)
            arpc_pkg::CSR_CHECK_CHANNELS:  check_channels_in  = csr_data[0];
            arpc_pkg::CSR_START_THRESHOLD: start_threshold_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_channels_ff  <= arpc_pkg::CHECK_CHANNELS_RESET;
         start_threshold_ff <= arpc_pkg::THRESHOLD_RESET;
      end else begin
         check_channels_ff  <= check_channels_in;
         start_threshold_ff <= start_threshold_in;
      end
   end

   assign cfg.check_channels  = check_channels_ff;
   assign cfg.start_threshold = start_threshold_ff;

endmodule

/* hw/rtl/arpc_core.sv */
module arpc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  arpc_pkg::item_type   item,
   input  arpc_pkg::cfg_type    cfg,
   output arpc_pkg::result_type result
);

   logic [15:0] gen_count_ff,      gen_count_in;
   logic [15:0] expected_count_ff, expected_count_in;
   logic        started_ff,        started_in;
   logic [15:0] nonzero_tally_ff,  nonzero_tally_in;
   logic [31:0] chan_err_ff,       chan_err_in;
   logic [31:0] sync_err_ff,       sync_err_in;
   logic [15:0] first_played_ff,   first_played_in;
   logic [11:0] latency_ff,        latency_in;

   logic [15:0] ramp_keep;
   logic [15:0] sample;
   logic [15:0] tally_base;
   logic        tally_inc;
   logic [15:0] in_ramp;

   // Generator and checker update for the item in the input register.
   always_comb begin
      ramp_keep         = cfg.check_channels ? arpc_pkg::RAMP_MASK_TAGGED
                                             : arpc_pkg::RAMP_MASK_FULL;
      sample            = '0;
      tally_base        = nonzero_tally_ff;
      tally_inc         = 1'b0;
      in_ramp           = item.captured & ramp_keep;
      gen_count_in      = gen_count_ff;
      expected_count_in = expected_count_ff;
      started_in        = started_ff;
      nonzero_tally_in  = nonzero_tally_ff;
      chan_err_in       = chan_err_ff;
      sync_err_in       = sync_err_ff;
      first_played_in   = first_played_ff;
      latency_in        = latency_ff;

      if (item.kind == arpc_pkg::KIND_GEN) begin
         sample = gen_count_ff & ramp_keep;
         if (cfg.check_channels) begin
            sample[15:12] = item.channel;
         end
         if (item.block_start) begin
            first_played_in = sample;
         end
         if (item.frame_end) begin
            gen_count_in = gen_count_ff + 16'd1;
         end
      end else begin
         if (item.block_start) begin
            latency_in = first_played_ff[11:0] - item.captured[11:0];
         end
         if (!started_ff) begin
            // Start detection: count nonzero words within the block.
            if (item.block_start) begin
               tally_base = '0;
            end
            tally_inc = (item.captured != '0) && (tally_base != arpc_pkg::TALLY_MAX);
            nonzero_tally_in = tally_base + {15'd0, tally_inc};
            if (item.block_end && (nonzero_tally_in > cfg.start_threshold)) begin
               started_in = 1'b1;
            end
         end else begin
            // Channel tag check.
            if (cfg.check_channels && (item.captured[15:12] != item.channel) &&
                (chan_err_ff != arpc_pkg::CHAN_ERR_MAX)) begin
               chan_err_in = chan_err_ff + 32'd1;
            end
            // Ramp continuity check, resyncing on a mismatch.
            if (in_ramp != (expected_count_ff & ramp_keep)) begin
               if (sync_err_ff != arpc_pkg::SYNC_ERR_MAX) begin
                  sync_err_in = sync_err_ff + 32'd1;
               end
               expected_count_in = in_ramp;
            end
            if (item.frame_end) begin
               expected_count_in = in_ramp + 16'd1;
            end
         end
      end

      result.sample_out          = sample;
      result.channel_error_count = chan_err_in;
      result.sync_error_count    = sync_err_in;
      result.measured_latency    = latency_in;
      result.is_started          = started_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_count_ff      <= '0;
         expected_count_ff <= '0;
         started_ff        <= 1'b0;
         nonzero_tally_ff  <= '0;
         chan_err_ff       <= '0;
         sync_err_ff       <= arpc_pkg::SYNC_ERR_RESET;
         first_played_ff   <= '0;
         latency_ff        <= '0;
      end else if (step) begin
         gen_count_ff      <= gen_count_in;
         expected_count_ff <= expected_count_in;
         started_ff        <= started_in;
         nonzero_tally_ff  <= nonzero_tally_in;
         chan_err_ff       <= chan_err_in;
         sync_err_ff       <= sync_err_in;
         first_played_ff   <= first_played_in;
         latency_ff        <= latency_in;
      end
   end

endmodule

/* tb/tb_audio_ramp_pattern_checker_top.sv */
module tb_audio_ramp_pattern_checker_top;

   localparam int QUIET_LIMIT = 2000;
   localparam int LONG_HOLD   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_kind = 1'b0;
   logic [3:0]  req_channel = 4'd0;
   logic        req_block_start = 1'b0;
   logic        req_frame_end = 1'b0;
   logic        req_block_end = 1'b0;
   logic [15:0] req_captured = 16'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_sample_out;
   logic [31:0] rsp_channel_error_count;
   logic signed [31:0] rsp_sync_error_count;
   logic [11:0] rsp_measured_latency;
   logic        rsp_is_started;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = 1'b0;
   logic [15:0] csr_data = 16'd0;

   audio_ramp_pattern_checker_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_kind(req_kind),
      .req_channel(req_channel), .req_block_start(req_block_start),
      .req_frame_end(req_frame_end), .req_block_end(req_block_end),
      .req_captured(req_captured),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_sample_out(rsp_sample_out),
      .rsp_channel_error_count(rsp_channel_error_count),
      .rsp_sync_error_count(rsp_sync_error_count),
      .rsp_measured_latency(rsp_measured_latency), .rsp_is_started(rsp_is_started),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // Clock with a period of 10.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Requests waiting to be offered and responses waiting to arrive.
   arpc_pkg::item_type   pending_requests[$];
   arpc_pkg::result_type expected_results[$];
   arpc_pkg::item_type   offered_item;
   arpc_pkg::result_type want_result;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int results_seen = 0;
   int taken_count = 0;
   int hold_left = 0;
   int quiet_cycles = 0;

   // Mirror of the configuration registers.
   logic        tag_mode = arpc_pkg::CHECK_CHANNELS_RESET;
   logic [15:0] threshold = arpc_pkg::THRESHOLD_RESET;

   // Mirror of the generator and checker state.
   logic [15:0] gen_ramp = 16'd0;
   logic [15:0] expected_ramp = 16'd0;
   logic        checking_on = 1'b0;
   logic [15:0] nonzero_seen = 16'd0;
   logic [31:0] chan_errs = 32'd0;
   logic [31:0] sync_errs = arpc_pkg::SYNC_ERR_RESET;
   logic [15:0] first_sample = 16'd0;
   logic [11:0] latency = 12'd0;

   // Ramp value that the stimulus loops back as captured data.
   logic [15:0] capture_ramp = 16'd0;

   // Advance the mirrored state by one request and return the response it causes.
   function automatic arpc_pkg::result_type ramp_check_response(
      input arpc_pkg::item_type it);
      arpc_pkg::result_type r;
      logic [15:0] mask;
      logic [15:0] sample;
      logic [15:0] ramp_in;
      mask = tag_mode ? arpc_pkg::RAMP_MASK_TAGGED : arpc_pkg::RAMP_MASK_FULL;
      sample = 16'd0;
      if (it.kind == arpc_pkg::KIND_GEN) begin
         sample = gen_ramp & mask;
         if (tag_mode) sample[15:12] = it.channel;
         if (it.block_start) first_sample = sample;
         if (it.frame_end) gen_ramp = gen_ramp + 16'd1;
      end else begin
         if (it.block_start) latency = first_sample[11:0] - it.captured[11:0];
         if (!checking_on) begin
            // Start detection: count nonzero captures over one block.
            if (it.block_start) nonzero_seen = 16'd0;
            if (it.captured != 16'd0 && nonzero_seen != arpc_pkg::TALLY_MAX)
               nonzero_seen = nonzero_seen + 16'd1;
            if (it.block_end && nonzero_seen > threshold) checking_on = 1'b1;
         end else begin
            ramp_in = it.captured & mask;
            if (tag_mode && it.captured[15:12] != it.channel &&
                chan_errs != arpc_pkg::CHAN_ERR_MAX)
               chan_errs = chan_errs + 32'd1;
            if (ramp_in != (expected_ramp & mask)) begin
               if (sync_errs != arpc_pkg::SYNC_ERR_MAX) sync_errs = sync_errs + 32'd1;
               expected_ramp = ramp_in;
            end
            if (it.frame_end) expected_ramp = ramp_in + 16'd1;
         end
      end
      r.sample_out = sample;
      r.channel_error_count = chan_errs;
      r.sync_error_count = sync_errs;
      r.measured_latency = latency;
      r.is_started = checking_on;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_count < 100) $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   // Driver: offers queued requests, predicting each one as it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) expected_results.push_back(ramp_check_response(offered_item));
         if (!req_valid || req_ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered_item = pending_requests.pop_front();
               req_valid <= 1'b1;
               req_kind <= offered_item.kind;
               req_channel <= offered_item.channel;
               req_block_start <= offered_item.block_start;
               req_frame_end <= offered_item.frame_end;
               req_block_end <= offered_item.block_end;
               req_captured <= offered_item.captured;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each response with the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with nothing expected",
                                         results_seen));
            end else begin
               want_result = expected_results.pop_front();
               if (rsp_sample_out !== want_result.sample_out)
                  report_mismatch($sformatf("response %0d sample_out got %h expected %h",
                     results_seen, rsp_sample_out, want_result.sample_out));
               if (rsp_channel_error_count !== want_result.channel_error_count)
                  report_mismatch($sformatf("response %0d channel_error_count got %h expected %h",
                     results_seen, rsp_channel_error_count, want_result.channel_error_count));
               if (rsp_sync_error_count !== want_result.sync_error_count)
                  report_mismatch($sformatf("response %0d sync_error_count got %h expected %h",
                     results_seen, rsp_sync_error_count, want_result.sync_error_count));
               if (rsp_measured_latency !== want_result.measured_latency)
                  report_mismatch($sformatf("response %0d measured_latency got %h expected %h",
                     results_seen, rsp_measured_latency, want_result.measured_latency));
               if (rsp_is_started !== want_result.is_started)
                  report_mismatch($sformatf("response %0d is_started got %b expected %b",
                     results_seen, rsp_is_started, want_result.is_started));
            end
            results_seen++;
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Receiver hold-off: twice stalls the responses for a long stretch so the
   // block fills and stalls its input while requests keep coming.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         taken_count <= taken_count + 1;
         if (taken_count == 600 || taken_count == 1800) hold_left <= LONG_HOLD;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Watchdog: counts cycles in which no handshake completes.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic push_item(input arpc_pkg::kind_type k, input logic [3:0] ch,
                            input logic bs, input logic fe, input logic be,
                            input logic [15:0] cap);
      arpc_pkg::item_type it;
      it.kind = k;
      it.channel = ch;
      it.block_start = bs;
      it.frame_end = fe;
      it.block_end = be;
      it.captured = cap;
      pending_requests.push_back(it);
   endtask

   // Wait until no request is queued, offered or awaiting its response.
   task automatic drain();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_results.size() != 0);
   endtask

   task automatic write_register(input logic idx, input logic [15:0] value);
      drain();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == arpc_pkg::CSR_CHECK_CHANNELS) tag_mode = value[0];
      else threshold = value;
      @(negedge clock);
   endtask

   // One block of frames: each slot plays a sample and captures the looped-back
   // ramp, with occasional corruption, ramp jumps and random noise requests.
   task automatic queue_block();
      int                 frames;
      int                 chans;
      int                 f;
      int                 c;
      logic               bs;
      logic               fe;
      logic               be;
      logic [15:0]        word;
      arpc_pkg::item_type junk;
      frames = $urandom_range(1, 4);
      chans = $urandom_range(1, 16);
      if ($urandom_range(0, 99) < 5) capture_ramp = 16'($urandom_range(0, 65535));
      for (f = 0; f < frames; f++) begin
         for (c = 0; c < chans; c++) begin
            bs = (f == 0 && c == 0);
            fe = (c == chans - 1);
            be = (f == frames - 1) && fe;
            if ($urandom_range(0, 99) < 8) begin
               junk.kind = arpc_pkg::kind_type'(1'($urandom_range(0, 1)));
               junk.channel = 4'($urandom_range(0, 15));
               junk.block_start = 1'($urandom_range(0, 1));
               junk.frame_end = 1'($urandom_range(0, 1));
               junk.block_end = 1'($urandom_range(0, 1));
               junk.captured = 16'($urandom_range(0, 65535));
               pending_requests.push_back(junk);
            end
            push_item(arpc_pkg::KIND_GEN, c[3:0], bs, fe, be, 16'($urandom_range(0, 65535)));
            word = tag_mode ? {c[3:0], capture_ramp[11:0]} : capture_ramp;
            if ($urandom_range(0, 99) < 3) word = word ^ (16'd1 << $urandom_range(0, 15));
            else if (tag_mode && $urandom_range(0, 99) < 3)
               word[15:12] = word[15:12] ^ 4'($urandom_range(1, 15));
            push_item(arpc_pkg::KIND_CAP, c[3:0], bs, fe, be, word);
            if (fe) capture_ramp = capture_ramp + 16'd1;
         end
      end
   endtask

   task automatic run_random_phase(input int send_pct, input int recv_pct, input int count);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      while (pending_requests.size() < count) queue_block();
      drain();
   endtask

   // Stimulus sequence.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 25;
      recv_idle_pct = 57;

      // First played sample on the top channel, then a block too sparse to start.
      push_item(arpc_pkg::KIND_GEN, 4'd15, 1'b1, 1'b1, 1'b0, 16'h0000);
      push_item(arpc_pkg::KIND_GEN, 4'd0, 1'b0, 1'b0, 1'b1, 16'hFFFF);
      push_item(arpc_pkg::KIND_CAP, 4'd0, 1'b1, 1'b0, 1'b0, 16'hFFFF);
      push_item(arpc_pkg::KIND_CAP, 4'd0, 1'b0, 1'b0, 1'b1, 16'h0000);

      // The largest threshold can never be exceeded.
      write_register(arpc_pkg::CSR_START_THRESHOLD, 16'hFFFF);
      push_item(arpc_pkg::KIND_CAP, 4'd7, 1'b1, 1'b1, 1'b1, 16'h1234);

      // Zero threshold: a zero capture does not count, one nonzero capture starts.
      write_register(arpc_pkg::CSR_START_THRESHOLD, 16'h0000);
      push_item(arpc_pkg::KIND_CAP, 4'd0, 1'b1, 1'b0, 1'b1, 16'h0000);
      push_item(arpc_pkg::KIND_CAP, 4'd0, 1'b1, 1'b1, 1'b1, 16'h0001);

      // Started: matching sample, tag error, ramp discontinuity with resync.
      push_item(arpc_pkg::KIND_CAP, 4'd3, 1'b0, 1'b1, 1'b0, 16'h3000);
      push_item(arpc_pkg::KIND_CAP, 4'd5, 1'b0, 1'b0, 1'b0, 16'h4001);
      push_item(arpc_pkg::KIND_CAP, 4'd0, 1'b0, 1'b1, 1'b0, 16'h07FF);

      // Channel checking off: full ramp, no tag, and the expectation wraps.
      write_register(arpc_pkg::CSR_CHECK_CHANNELS, 16'h0000);
      push_item(arpc_pkg::KIND_GEN, 4'd9, 1'b0, 1'b1, 1'b0, 16'h5555);
      push_item(arpc_pkg::KIND_CAP, 4'd2, 1'b0, 1'b0, 1'b0, 16'h0800);
      push_item(arpc_pkg::KIND_CAP, 4'd2, 1'b0, 1'b1, 1'b0, 16'hFFFF);
      push_item(arpc_pkg::KIND_CAP, 4'd2, 1'b0, 1'b0, 1'b0, 16'h0000);

      write_register(arpc_pkg::CSR_CHECK_CHANNELS, 16'h0001);
      push_item(arpc_pkg::KIND_CAP, 4'd15, 1'b0, 1'b0, 1'b0, 16'hF000);

      // Random phases under the three idling regimes.
      write_register(arpc_pkg::CSR_START_THRESHOLD, 16'($urandom_range(0, 65535)));
      run_random_phase(25, 57, 650);
      write_register(arpc_pkg::CSR_CHECK_CHANNELS, 16'h0000);
      write_register(arpc_pkg::CSR_START_THRESHOLD, 16'($urandom_range(0, 65535)));
      run_random_phase(57, 25, 650);
      write_register(arpc_pkg::CSR_CHECK_CHANNELS, 16'h0001);
      write_register(arpc_pkg::CSR_START_THRESHOLD, 16'hFFFF);
      run_random_phase(0, 0, 700);

      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_csr.sv
hw/rtl/arpc_core.sv
hw/rtl/audio_ramp_pattern_checker_top.sv
tb/tb_audio_ramp_pattern_checker_top.sv
